// ===== rtl/pcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics package
// Shared widths, feature codes, register codes and the structs that pass
// between the stages of the cluster statistics unit.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int VALUE_W    = 50;
    localparam int DIST_W     = 34;
    localparam int IN_COORD_W = 17;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int FEAT_NUM   = 14;
    localparam int FEAT_IDX_W = 4;
    localparam int SPAN_W     = 19;

    localparam logic [FEAT_IDX_W-1:0] FEAT_COUNT    = 4'd0;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MIN_DIST = 4'd1;
    localparam logic [FEAT_IDX_W-1:0] FEAT_M00      = 4'd2;
    localparam logic [FEAT_IDX_W-1:0] FEAT_M01      = 4'd3;
    localparam logic [FEAT_IDX_W-1:0] FEAT_M02      = 4'd4;
    localparam logic [FEAT_IDX_W-1:0] FEAT_M11      = 4'd5;
    localparam logic [FEAT_IDX_W-1:0] FEAT_M12      = 4'd6;
    localparam logic [FEAT_IDX_W-1:0] FEAT_M22      = 4'd7;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MIN_X    = 4'd8;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MIN_Y    = 4'd9;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MIN_Z    = 4'd10;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MAX_X    = 4'd11;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MAX_Y    = 4'd12;
    localparam logic [FEAT_IDX_W-1:0] FEAT_MAX_Z    = 4'd13;
    localparam logic [FEAT_IDX_W-1:0] FEAT_LAST_IDX = FEAT_MAX_Z;

    localparam logic [CFG_W-1:0] RESET_MIN_FOOTPRINT = 17'd200;
    localparam logic [CFG_W-1:0] RESET_MAX_FOOTPRINT = 17'd1000;
    localparam logic [CFG_W-1:0] RESET_MIN_HEIGHT    = 17'd500;
    localparam logic [CFG_W-1:0] RESET_MAX_HEIGHT    = 17'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_ENABLE   = 3'd0,
        REG_MIN_FOOTPRINT = 3'd1,
        REG_MAX_FOOTPRINT = 3'd2,
        REG_MIN_HEIGHT    = 3'd3,
        REG_MAX_HEIGHT    = 3'd4
    } cfg_reg_t;

    typedef logic [FEAT_NUM-1:0][VALUE_W-1:0] feature_set_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] min_footprint;
        logic [CFG_W-1:0] max_footprint;
        logic [CFG_W-1:0] min_height;
        logic [CFG_W-1:0] max_height;
    } limits_t;

    typedef struct packed {
        logic         load;
        logic         overflow;
        feature_set_t features;
    } snapshot_t;

endpackage

// ===== rtl/pcs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics channels
// Valid/ready channels for incoming points and outgoing features.
// ----------------------------------------------------------------------------
interface pcs_point_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] point_x;
    logic signed [16:0] point_y;
    logic signed [16:0] point_z;
    logic               last_point;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input last_point, output ready);
endinterface

interface pcs_feature_if;
    logic               valid;
    logic               ready;
    logic [3:0]         feature_index;
    logic signed [49:0] feature_value;
    logic               last_feature;
    logic               size_ok;
    logic               overflow;

    modport source (output valid, output feature_index, output feature_value,
                    output last_feature, output size_ok, output overflow, input ready);
    modport sink   (input valid, input feature_index, input feature_value,
                    input last_feature, input size_ok, input overflow, output ready);
endinterface

// ===== rtl/pcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics front end
// Registers the incoming point, then registers its squares and cross products.
// ----------------------------------------------------------------------------
module pcs_front
    import pcs_pkg::*;
#(
    parameter int COORD_BITS = 17
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    pcs_point_if.sink                    points,
    input  logic                         advance,
    output stage_ctrl_t                  prod_ctrl,
    output logic signed [COORD_BITS-1:0] prod_x,
    output logic signed [COORD_BITS-1:0] prod_y,
    output logic signed [COORD_BITS-1:0] prod_z,
    output logic signed [2*COORD_BITS-1:0] prod_xx,
    output logic signed [2*COORD_BITS-1:0] prod_yy,
    output logic signed [2*COORD_BITS-1:0] prod_zz,
    output logic signed [2*COORD_BITS-1:0] prod_xy,
    output logic signed [2*COORD_BITS-1:0] prod_xz,
    output logic signed [2*COORD_BITS-1:0] prod_yz
);

    localparam int PROD_W = 2 * COORD_BITS;

    stage_ctrl_t                  in_ctrl_reg;
    stage_ctrl_t                  prod_ctrl_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] z_reg;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic signed [COORD_BITS-1:0] pz_reg;
    logic signed [PROD_W-1:0]     xx_reg;
    logic signed [PROD_W-1:0]     yy_reg;
    logic signed [PROD_W-1:0]     zz_reg;
    logic signed [PROD_W-1:0]     xy_reg;
    logic signed [PROD_W-1:0]     xz_reg;
    logic signed [PROD_W-1:0]     yz_reg;
    logic signed [PROD_W-1:0]     xx_next;
    logic signed [PROD_W-1:0]     yy_next;
    logic signed [PROD_W-1:0]     zz_next;
    logic signed [PROD_W-1:0]     xy_next;
    logic signed [PROD_W-1:0]     xz_next;
    logic signed [PROD_W-1:0]     yz_next;

    assign points.ready = advance;

    always_comb
    begin
        xx_next = x_reg * x_reg;
        yy_next = y_reg * y_reg;
        zz_next = z_reg * z_reg;
        xy_next = x_reg * y_reg;
        xz_next = x_reg * z_reg;
        yz_next = y_reg * z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg   <= '0;
            prod_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            in_ctrl_reg.valid <= points.valid;
            in_ctrl_reg.last  <= points.last_point;
            prod_ctrl_reg     <= in_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg  <= points.point_x[COORD_BITS-1:0];
            y_reg  <= points.point_y[COORD_BITS-1:0];
            z_reg  <= points.point_z[COORD_BITS-1:0];
            px_reg <= x_reg;
            py_reg <= y_reg;
            pz_reg <= z_reg;
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            xy_reg <= xy_next;
            xz_reg <= xz_next;
            yz_reg <= yz_next;
        end
    end

    assign prod_ctrl = prod_ctrl_reg;
    assign prod_x    = px_reg;
    assign prod_y    = py_reg;
    assign prod_z    = pz_reg;
    assign prod_xx   = xx_reg;
    assign prod_yy   = yy_reg;
    assign prod_zz   = zz_reg;
    assign prod_xy   = xy_reg;
    assign prod_xz   = xz_reg;
    assign prod_yz   = yz_reg;

endmodule

// ===== rtl/pcs_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics accumulator
// Keeps count, minimum distance, inertia sums and the bounding box of the
// current cluster and hands a snapshot of them over on the last point.
// ----------------------------------------------------------------------------
module pcs_accum
    import pcs_pkg::*;
#(
    parameter int COORD_BITS = 17,
    parameter int MAX_POINTS = 32768
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stage_ctrl_t                    prod_ctrl,
    input  logic signed [COORD_BITS-1:0]   prod_x,
    input  logic signed [COORD_BITS-1:0]   prod_y,
    input  logic signed [COORD_BITS-1:0]   prod_z,
    input  logic signed [2*COORD_BITS-1:0] prod_xx,
    input  logic signed [2*COORD_BITS-1:0] prod_yy,
    input  logic signed [2*COORD_BITS-1:0] prod_zz,
    input  logic signed [2*COORD_BITS-1:0] prod_xy,
    input  logic signed [2*COORD_BITS-1:0] prod_xz,
    input  logic signed [2*COORD_BITS-1:0] prod_yz,
    input  logic                           can_load,
    output logic                           advance,
    output snapshot_t                      snap
);

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [DIST_W-1:0]              dist_reg;
    logic [DIST_W-1:0]              dist_next;
    logic signed [VALUE_W-1:0]      sum_reg [6];
    logic signed [VALUE_W-1:0]      sum_next [6];
    logic signed [COORD_BITS-1:0]   min_reg [3];
    logic signed [COORD_BITS-1:0]   min_next [3];
    logic signed [COORD_BITS-1:0]   max_reg [3];
    logic signed [COORD_BITS-1:0]   max_next [3];
    logic                           ovf_reg;
    logic                           ovf_next;
    logic signed [COORD_BITS-1:0]   pt [3];
    logic signed [VALUE_W-1:0]      ext_xx;
    logic signed [VALUE_W-1:0]      ext_yy;
    logic signed [VALUE_W-1:0]      ext_zz;
    logic signed [VALUE_W-1:0]      ext_xy;
    logic signed [VALUE_W-1:0]      ext_xz;
    logic signed [VALUE_W-1:0]      ext_yz;
    logic signed [VALUE_W-1:0]      dist_sum;
    logic                           take;

    assign pt[0] = prod_x;
    assign pt[1] = prod_y;
    assign pt[2] = prod_z;

    assign ext_xx = {{(VALUE_W-PROD_W){prod_xx[PROD_W-1]}}, prod_xx};
    assign ext_yy = {{(VALUE_W-PROD_W){prod_yy[PROD_W-1]}}, prod_yy};
    assign ext_zz = {{(VALUE_W-PROD_W){prod_zz[PROD_W-1]}}, prod_zz};
    assign ext_xy = {{(VALUE_W-PROD_W){prod_xy[PROD_W-1]}}, prod_xy};
    assign ext_xz = {{(VALUE_W-PROD_W){prod_xz[PROD_W-1]}}, prod_xz};
    assign ext_yz = {{(VALUE_W-PROD_W){prod_yz[PROD_W-1]}}, prod_yz};
    assign dist_sum = ext_xx + ext_yy + ext_zz;

    assign advance = !(prod_ctrl.valid && prod_ctrl.last && !can_load);
    assign take    = prod_ctrl.valid && advance;

    always_comb
    begin
        count_next = count_reg;
        dist_next  = dist_reg;
        ovf_next   = ovf_reg;
        for (int i = 0; i < 6; i++)
        begin
            sum_next[i] = sum_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            min_next[i] = min_reg[i];
            max_next[i] = max_reg[i];
        end
        if (count_reg >= MAX_CNT)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            if (dist_sum[DIST_W-1:0] < dist_reg)
            begin
                dist_next = dist_sum[DIST_W-1:0];
            end
            sum_next[0] = sum_reg[0] + ext_yy + ext_zz;
            sum_next[1] = sum_reg[1] - ext_xy;
            sum_next[2] = sum_reg[2] - ext_xz;
            sum_next[3] = sum_reg[3] + ext_xx + ext_zz;
            sum_next[4] = sum_reg[4] - ext_yz;
            sum_next[5] = sum_reg[5] + ext_xx + ext_yy;
            for (int i = 0; i < 3; i++)
            begin
                if (pt[i] < min_reg[i])
                begin
                    min_next[i] = pt[i];
                end
                if (pt[i] > max_reg[i])
                begin
                    max_next[i] = pt[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dist_reg  <= '1;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                sum_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= COORD_MAX;
                max_reg[i] <= COORD_MIN;
            end
        end
        else if (take)
        begin
            if (prod_ctrl.last)
            begin
                count_reg <= '0;
                dist_reg  <= '1;
                ovf_reg   <= 1'b0;
                for (int i = 0; i < 6; i++)
                begin
                    sum_reg[i] <= '0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    min_reg[i] <= COORD_MAX;
                    max_reg[i] <= COORD_MIN;
                end
            end
            else
            begin
                count_reg <= count_next;
                dist_reg  <= dist_next;
                ovf_reg   <= ovf_next;
                for (int i = 0; i < 6; i++)
                begin
                    sum_reg[i] <= sum_next[i];
                end
                for (int i = 0; i < 3; i++)
                begin
                    min_reg[i] <= min_next[i];
                    max_reg[i] <= max_next[i];
                end
            end
        end
    end

    always_comb
    begin
        snap.load     = take && prod_ctrl.last;
        snap.overflow = ovf_next;
        snap.features = '0;
        snap.features[FEAT_COUNT]    = VALUE_W'(count_next);
        snap.features[FEAT_MIN_DIST] = VALUE_W'(dist_next);
        snap.features[FEAT_M00]      = sum_next[0];
        snap.features[FEAT_M01]      = sum_next[1];
        snap.features[FEAT_M02]      = sum_next[2];
        snap.features[FEAT_M11]      = sum_next[3];
        snap.features[FEAT_M12]      = sum_next[4];
        snap.features[FEAT_M22]      = sum_next[5];
        snap.features[FEAT_MIN_X] = {{(VALUE_W-COORD_BITS){min_next[0][COORD_BITS-1]}}, min_next[0]};
        snap.features[FEAT_MIN_Y] = {{(VALUE_W-COORD_BITS){min_next[1][COORD_BITS-1]}}, min_next[1]};
        snap.features[FEAT_MIN_Z] = {{(VALUE_W-COORD_BITS){min_next[2][COORD_BITS-1]}}, min_next[2]};
        snap.features[FEAT_MAX_X] = {{(VALUE_W-COORD_BITS){max_next[0][COORD_BITS-1]}}, max_next[0]};
        snap.features[FEAT_MAX_Y] = {{(VALUE_W-COORD_BITS){max_next[1][COORD_BITS-1]}}, max_next[1]};
        snap.features[FEAT_MAX_Z] = {{(VALUE_W-COORD_BITS){max_next[2][COORD_BITS-1]}}, max_next[2]};
    end

endmodule

// ===== rtl/pcs_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics feature emitter
// Holds one cluster's features and sends them out in index order together
// with the box size check.
// ----------------------------------------------------------------------------
module pcs_emit
    import pcs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  snapshot_t     snap,
    input  limits_t       limits,
    output logic          can_load,
    pcs_feature_if.source features
);

    feature_set_t            feat_reg;
    logic                    ovf_reg;
    logic                    busy_reg;
    logic [FEAT_IDX_W-1:0]   idx_reg;
    logic                    done;
    logic                    size_ok;

    function automatic logic span_ok(input logic [VALUE_W-1:0] lo,
                                     input logic [VALUE_W-1:0] hi,
                                     input logic [CFG_W-1:0]   min_mm,
                                     input logic [CFG_W-1:0]   max_mm);
        logic signed [SPAN_W-1:0] span;
        logic signed [SPAN_W-1:0] lo_mm;
        logic signed [SPAN_W-1:0] hi_mm;
        span  = $signed(hi[SPAN_W-1:0]) - $signed(lo[SPAN_W-1:0]);
        lo_mm = $signed({{(SPAN_W-CFG_W){1'b0}}, min_mm});
        hi_mm = $signed({{(SPAN_W-CFG_W){1'b0}}, max_mm});
        return !(span < lo_mm || span > hi_mm);
    endfunction

    assign done     = busy_reg && features.ready && (idx_reg == FEAT_LAST_IDX);
    assign can_load = !busy_reg || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (snap.load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= FEAT_COUNT;
        end
        else if (busy_reg && features.ready)
        begin
            if (idx_reg == FEAT_LAST_IDX)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.load)
        begin
            feat_reg <= snap.features;
            ovf_reg  <= snap.overflow;
        end
    end

    always_comb
    begin
        size_ok = 1'b1;
        if (limits.enable)
        begin
            size_ok = span_ok(feat_reg[FEAT_MIN_X], feat_reg[FEAT_MAX_X],
                              limits.min_footprint, limits.max_footprint)
                   && span_ok(feat_reg[FEAT_MIN_Y], feat_reg[FEAT_MAX_Y],
                              limits.min_footprint, limits.max_footprint)
                   && span_ok(feat_reg[FEAT_MIN_Z], feat_reg[FEAT_MAX_Z],
                              limits.min_height, limits.max_height);
        end
    end

    assign features.valid         = busy_reg;
    assign features.feature_index = idx_reg;
    assign features.feature_value = feat_reg[idx_reg];
    assign features.last_feature  = (idx_reg == FEAT_LAST_IDX);
    assign features.size_ok       = size_ok;
    assign features.overflow      = ovf_reg;

endmodule

// ===== rtl/point_cluster_statistics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics unit
// Accumulates per-cluster point statistics and emits fourteen features with
// a bounding box size check at the end of each cluster.
// ----------------------------------------------------------------------------
// The unit takes one point per clock cycle. A point passes an input register
// and a product register holding its six squares and cross products, and is
// folded into the cluster accumulators. On the last point the finished
// statistics are copied into a feature buffer and the accumulators clear, so
// the next cluster streams in without a gap while the features leave at one
// per cycle if the output is ready. Input stalls only when a second cluster
// ends before the previous cluster's features are all taken, so if the output
// stays ready clusters of fourteen points or more keep the full rate of one
// point per cycle. The user must write configuration registers through the
// plain write port only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module point_cluster_statistics_unit
    import pcs_pkg::*;
#(
    parameter int MAX_POINTS = 32768,
    parameter int COORD_BITS = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    pcs_point_if.sink            points,
    pcs_feature_if.source        features
);

    limits_t                        limits_reg;
    stage_ctrl_t                    prod_ctrl;
    logic signed [COORD_BITS-1:0]   prod_x;
    logic signed [COORD_BITS-1:0]   prod_y;
    logic signed [COORD_BITS-1:0]   prod_z;
    logic signed [2*COORD_BITS-1:0] prod_xx;
    logic signed [2*COORD_BITS-1:0] prod_yy;
    logic signed [2*COORD_BITS-1:0] prod_zz;
    logic signed [2*COORD_BITS-1:0] prod_xy;
    logic signed [2*COORD_BITS-1:0] prod_xz;
    logic signed [2*COORD_BITS-1:0] prod_yz;
    logic                           advance;
    logic                           can_load;
    snapshot_t                      snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.enable        <= 1'b0;
            limits_reg.min_footprint <= RESET_MIN_FOOTPRINT;
            limits_reg.max_footprint <= RESET_MAX_FOOTPRINT;
            limits_reg.min_height    <= RESET_MIN_HEIGHT;
            limits_reg.max_height    <= RESET_MAX_HEIGHT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SIZE_ENABLE:   limits_reg.enable        <= cfg_data[0];
                REG_MIN_FOOTPRINT: limits_reg.min_footprint <= cfg_data;
                REG_MAX_FOOTPRINT: limits_reg.max_footprint <= cfg_data;
                REG_MIN_HEIGHT:    limits_reg.min_height    <= cfg_data;
                REG_MAX_HEIGHT:    limits_reg.max_height    <= cfg_data;
                default:           ;
            endcase
        end
    end

    pcs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .advance   (advance),
        .prod_ctrl (prod_ctrl),
        .prod_x    (prod_x),
        .prod_y    (prod_y),
        .prod_z    (prod_z),
        .prod_xx   (prod_xx),
        .prod_yy   (prod_yy),
        .prod_zz   (prod_zz),
        .prod_xy   (prod_xy),
        .prod_xz   (prod_xz),
        .prod_yz   (prod_yz)
    );

    pcs_accum #(
        .COORD_BITS (COORD_BITS),
        .MAX_POINTS (MAX_POINTS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod_ctrl (prod_ctrl),
        .prod_x    (prod_x),
        .prod_y    (prod_y),
        .prod_z    (prod_z),
        .prod_xx   (prod_xx),
        .prod_yy   (prod_yy),
        .prod_zz   (prod_zz),
        .prod_xy   (prod_xy),
        .prod_xz   (prod_xz),
        .prod_yz   (prod_yz),
        .can_load  (can_load),
        .advance   (advance),
        .snap      (snap)
    );

    pcs_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .snap     (snap),
        .limits   (limits_reg),
        .can_load (can_load),
        .features (features)
    );

endmodule

// ===== tb/tb_point_cluster_statistics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cluster statistics unit testbench
// Streams clusters of points into the unit and predicts the fourteen
// features of every cluster: point count, nearest squared distance, inertia
// tensor sums, bounding box and the box size check. Each feature that leaves
// the unit is compared with the oldest prediction. Directed clusters cover
// coordinate extremes, the size limits, inconsistent limits and register
// masking. A long output hold follows, then random phases under changing
// limits, most of them with random gaps on one or both channels.
// ----------------------------------------------------------------------------
module tb_point_cluster_statistics_unit;
    import pcs_pkg::*;

    localparam int     CLUSTER_CAP   = 32768;
    localparam logic signed [IN_COORD_W-1:0] COORD_HI = {1'b0, {(IN_COORD_W-1){1'b1}}};
    localparam logic signed [IN_COORD_W-1:0] COORD_LO = {1'b1, {(IN_COORD_W-1){1'b0}}};
    localparam int     COORD_SPAN    = 2 ** IN_COORD_W - 1;
    localparam int     CFG_TOP       = 2 ** CFG_W - 1;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     PHASE_ITEMS   = 55;
    localparam longint TIMEOUT_NS    = 10_000_000;

    typedef struct {
        logic [FEAT_IDX_W-1:0]     index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      ok;
        logic                      ovf;
    } feature_t;

    typedef struct {
        logic [CFG_W-1:0] enable_word;
        logic [CFG_W-1:0] min_fp;
        logic [CFG_W-1:0] max_fp;
        logic [CFG_W-1:0] min_ht;
        logic [CFG_W-1:0] max_ht;
    } limits_cfg_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pcs_point_if   point_ch ();
    pcs_feature_if feature_ch ();

    point_cluster_statistics_unit #(
        .MAX_POINTS (CLUSTER_CAP),
        .COORD_BITS (IN_COORD_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .points       (point_ch),
        .features     (feature_ch)
    );

    logic             lim_enable  = 1'b0;
    logic [CFG_W-1:0] lim_min_fp  = RESET_MIN_FOOTPRINT;
    logic [CFG_W-1:0] lim_max_fp  = RESET_MAX_FOOTPRINT;
    logic [CFG_W-1:0] lim_min_ht  = RESET_MIN_HEIGHT;
    logic [CFG_W-1:0] lim_max_ht  = RESET_MAX_HEIGHT;

    longint   clu_feat [FEAT_NUM];
    bit       clu_overflow;
    feature_t pending_features [$];

    int mismatch_count    = 0;
    bit input_idle_on     = 1'b0;
    bit output_idle_on    = 1'b0;
    int long_hold_request = 0;
    int hold_left         = 0;
    int stall_left        = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_point_cluster_statistics_unit: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [IN_COORD_W-1:0] random_coord();
        logic [IN_COORD_W-1:0] raw;
        raw = IN_COORD_W'($urandom_range(0, COORD_SPAN));
        return raw;
    endfunction

    function automatic void clear_cluster();
        clu_feat[FEAT_COUNT]    = 0;
        clu_feat[FEAT_MIN_DIST] = longint'((64'd1 << DIST_W) - 1);
        for (int k = FEAT_M00; k <= FEAT_M22; k++)
            clu_feat[k] = 0;
        for (int k = 0; k < 3; k++)
        begin
            clu_feat[FEAT_MIN_X + k] = COORD_HI;
            clu_feat[FEAT_MAX_X + k] = COORD_LO;
        end
        clu_overflow = 1'b0;
    endfunction

    function automatic bit span_fits(input longint lo, input longint hi,
                                     input logic [CFG_W-1:0] lo_lim,
                                     input logic [CFG_W-1:0] hi_lim);
        longint span;
        span = hi - lo;
        return !(span < longint'(lo_lim) || span > longint'(hi_lim));
    endfunction

    // Folds one accepted point into the cluster and, on the last point,
    // queues the fourteen features that the unit must emit.
    function automatic void fold_point(input logic signed [IN_COORD_W-1:0] px,
                                       input logic signed [IN_COORD_W-1:0] py,
                                       input logic signed [IN_COORD_W-1:0] pz,
                                       input logic last);
        longint   p [3];
        longint   sq [3];
        longint   d2;
        bit       ok;
        feature_t item;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        if (clu_feat[FEAT_COUNT] >= CLUSTER_CAP)
            clu_overflow = 1'b1;
        else
        begin
            for (int k = 0; k < 3; k++)
                sq[k] = p[k] * p[k];
            d2 = sq[0] + sq[1] + sq[2];
            clu_feat[FEAT_COUNT]++;
            if (d2 < clu_feat[FEAT_MIN_DIST])
                clu_feat[FEAT_MIN_DIST] = d2;
            clu_feat[FEAT_M00] += sq[1] + sq[2];
            clu_feat[FEAT_M01] -= p[0] * p[1];
            clu_feat[FEAT_M02] -= p[0] * p[2];
            clu_feat[FEAT_M11] += sq[0] + sq[2];
            clu_feat[FEAT_M12] -= p[1] * p[2];
            clu_feat[FEAT_M22] += sq[0] + sq[1];
            for (int k = 0; k < 3; k++)
            begin
                if (p[k] < clu_feat[FEAT_MIN_X + k])
                    clu_feat[FEAT_MIN_X + k] = p[k];
                if (p[k] > clu_feat[FEAT_MAX_X + k])
                    clu_feat[FEAT_MAX_X + k] = p[k];
            end
        end
        if (!last)
            return;
        ok = 1'b1;
        if (lim_enable)
            ok = span_fits(clu_feat[FEAT_MIN_X], clu_feat[FEAT_MAX_X], lim_min_fp, lim_max_fp)
              && span_fits(clu_feat[FEAT_MIN_Y], clu_feat[FEAT_MAX_Y], lim_min_fp, lim_max_fp)
              && span_fits(clu_feat[FEAT_MIN_Z], clu_feat[FEAT_MAX_Z], lim_min_ht, lim_max_ht);
        for (int i = 0; i < FEAT_NUM; i++)
        begin
            item.index = i[FEAT_IDX_W-1:0];
            item.value = clu_feat[i][VALUE_W-1:0];
            item.last  = (i == FEAT_LAST_IDX);
            item.ok    = ok;
            item.ovf   = clu_overflow;
            pending_features = {pending_features, item};
        end
        clear_cluster();
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        case (idx)
            REG_SIZE_ENABLE:   lim_enable = data[0];
            REG_MIN_FOOTPRINT: lim_min_fp = data;
            REG_MAX_FOOTPRINT: lim_max_fp = data;
            REG_MIN_HEIGHT:    lim_min_ht = data;
            REG_MAX_HEIGHT:    lim_max_ht = data;
            default:           ;
        endcase
    endfunction

    task automatic wait_until_idle();
        point_ch.valid <= 1'b0;
        while (pending_features.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the size enable alone, or every register and then the unmapped
    // indexes with random data, which the unit must ignore.
    task automatic program_registers(input limits_cfg_t cfg, input bit enable_only);
        logic [CFG_W-1:0] data;
        int               top_idx;
        wait_until_idle();
        top_idx = enable_only ? int'(REG_SIZE_ENABLE) : 2 ** CFG_IDX_W - 1;
        for (int i = 0; i <= top_idx; i++)
        begin
            case (i)
                REG_SIZE_ENABLE:   data = cfg.enable_word;
                REG_MIN_FOOTPRINT: data = cfg.min_fp;
                REG_MAX_FOOTPRINT: data = cfg.max_fp;
                REG_MIN_HEIGHT:    data = cfg.min_ht;
                REG_MAX_HEIGHT:    data = cfg.max_ht;
                default:           data = CFG_W'($urandom_range(0, CFG_TOP));
            endcase
            cfg_write_en <= 1'b1;
            cfg_index    <= i[CFG_IDX_W-1:0];
            cfg_data     <= data;
            @(posedge clk);
            store_register(i[CFG_IDX_W-1:0], data);
        end
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_point(input logic signed [IN_COORD_W-1:0] px,
                              input logic signed [IN_COORD_W-1:0] py,
                              input logic signed [IN_COORD_W-1:0] pz,
                              input logic last);
        int gap;
        gap = input_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid      <= 1'b1;
        point_ch.point_x    <= px;
        point_ch.point_y    <= py;
        point_ch.point_z    <= pz;
        point_ch.last_point <= last;
        do
            @(posedge clk);
        while (!point_ch.ready);
        fold_point(px, py, pz, last);
    endtask

    task automatic send_box(input int w, input int d, input int h);
        send_point(IN_COORD_W'(-w), '0, IN_COORD_W'(-h), 1'b0);
        send_point('0, IN_COORD_W'(d), '0, 1'b1);
    endtask

    function automatic longint pick_span(input logic [CFG_W-1:0] lo_lim,
                                         input logic [CFG_W-1:0] hi_lim);
        longint s;
        case ($urandom_range(0, 5))
            0:       s = lo_lim;
            1:       s = hi_lim;
            2:       s = longint'(lo_lim) - 1;
            3:       s = longint'(hi_lim) + 1;
            4:       s = $urandom_range(0, 2500);
            default: s = $urandom_range(0, COORD_SPAN);
        endcase
        if (s < 0)
            s = 0;
        if (s > COORD_SPAN)
            s = COORD_SPAN;
        return s;
    endfunction

    // A cluster whose box spans are aimed at the current limits; two points
    // usually sit on opposite corners so the spans come out exact.
    task automatic send_shaped_cluster(input int n);
        longint                       lo [3];
        longint                       span [3];
        longint                       v;
        logic signed [IN_COORD_W-1:0] c [3];
        int                           ia;
        int                           ib;
        for (int k = 0; k < 3; k++)
        begin
            span[k] = (k == 2) ? pick_span(lim_min_ht, lim_max_ht)
                               : pick_span(lim_min_fp, lim_max_fp);
            lo[k] = longint'($urandom_range(0, COORD_SPAN - int'(span[k]))) + COORD_LO;
        end
        ia = $urandom_range(0, n - 1);
        ib = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (i == ia)
                    v = lo[k];
                else if (i == ib)
                    v = lo[k] + span[k];
                else
                    v = lo[k] + longint'($urandom_range(0, int'(span[k])));
                c[k] = v[IN_COORD_W-1:0];
            end
            send_point(c[0], c[1], c[2], i == n - 1);
        end
    endtask

    task automatic send_noise_cluster(input int n);
        for (int i = 0; i < n; i++)
            send_point(random_coord(), random_coord(), random_coord(), i == n - 1);
    endtask

    task automatic test_extreme_points();
        input_idle_on  = 1'b0;
        output_idle_on = 1'b0;
        send_point(COORD_HI, COORD_HI, COORD_HI, 1'b1);
        send_point(COORD_LO, COORD_LO, COORD_LO, 1'b1);
        send_point('0, '0, '0, 1'b1);
        send_point(COORD_HI, COORD_LO, '0, 1'b1);
        send_point(COORD_LO, COORD_HI, IN_COORD_W'(-1), 1'b0);
        send_point(IN_COORD_W'(1), IN_COORD_W'(-1), COORD_HI, 1'b1);
        wait_until_idle();
    endtask

    task automatic test_size_limits();
        limits_cfg_t cfg;
        input_idle_on  = 1'b1;
        output_idle_on = 1'b1;
        cfg = '{enable_word: CFG_W'(1), min_fp: RESET_MIN_FOOTPRINT,
                max_fp: RESET_MAX_FOOTPRINT, min_ht: RESET_MIN_HEIGHT,
                max_ht: RESET_MAX_HEIGHT};
        // Only the enable is written here, so the reset limits are in force.
        program_registers(cfg, 1'b1);
        send_box(RESET_MIN_FOOTPRINT, RESET_MAX_FOOTPRINT, RESET_MIN_HEIGHT);
        send_box(RESET_MAX_FOOTPRINT, RESET_MIN_FOOTPRINT, RESET_MAX_HEIGHT);
        send_box(RESET_MIN_FOOTPRINT - 1, RESET_MAX_FOOTPRINT, RESET_MAX_HEIGHT);
        send_box(RESET_MIN_FOOTPRINT, RESET_MAX_FOOTPRINT + 1, RESET_MIN_HEIGHT);
        send_box(RESET_MAX_FOOTPRINT, RESET_MAX_FOOTPRINT, RESET_MIN_HEIGHT - 1);
        send_box(RESET_MIN_FOOTPRINT, RESET_MIN_FOOTPRINT, RESET_MAX_HEIGHT + 1);
        // A footprint minimum above its maximum fails both footprint checks.
        cfg.min_fp = RESET_MAX_FOOTPRINT;
        cfg.max_fp = RESET_MIN_FOOTPRINT;
        program_registers(cfg, 1'b0);
        send_box(600, 600, 1000);
        // Only bit zero of the enable word counts.
        cfg.enable_word = {{(CFG_W - 1){1'b1}}, 1'b0};
        program_registers(cfg, 1'b0);
        send_box(600, 600, 1000);
        wait_until_idle();
    endtask

    task automatic test_output_hold();
        input_idle_on  = 1'b0;
        output_idle_on = 1'b1;
        long_hold_request = 400;
        for (int i = 0; i < 20; i++)
            send_shaped_cluster($urandom_range(1, 2));
        wait_until_idle();
    endtask

    task automatic test_random_phases();
        limits_cfg_t cfg;
        int          sent;
        int          n;
        int          r;
        for (int phase = 0; phase < 6; phase++)
        begin
            cfg = '{enable_word: CFG_W'(1), min_fp: RESET_MIN_FOOTPRINT,
                    max_fp: RESET_MAX_FOOTPRINT, min_ht: RESET_MIN_HEIGHT,
                    max_ht: RESET_MAX_HEIGHT};
            case (phase)
                1:
                begin
                    cfg.min_fp = '0;
                    cfg.max_fp = CFG_W'(CFG_TOP);
                    cfg.min_ht = '0;
                    cfg.max_ht = CFG_W'(CFG_TOP);
                end
                2:
                begin
                    cfg.min_fp = CFG_W'($urandom_range(100, 800));
                    cfg.max_fp = cfg.min_fp;
                    cfg.min_ht = CFG_W'($urandom_range(100, 1500));
                    cfg.max_ht = cfg.min_ht;
                end
                3:
                begin
                    cfg.min_fp = CFG_W'($urandom_range(0, 1500));
                    cfg.max_fp = CFG_W'(cfg.min_fp + $urandom_range(0, 1500));
                    cfg.min_ht = CFG_W'($urandom_range(0, 1500));
                    cfg.max_ht = CFG_W'(cfg.min_ht + $urandom_range(0, 1500));
                end
                4:
                begin
                    cfg.max_fp = CFG_W'($urandom_range(0, 1000));
                    cfg.min_fp = CFG_W'(cfg.max_fp + $urandom_range(1, 1000));
                    cfg.min_ht = CFG_W'($urandom_range(0, 3000));
                    cfg.max_ht = CFG_W'($urandom_range(0, 3000));
                end
                5:
                begin
                    cfg.enable_word = CFG_W'($urandom_range(0, CFG_TOP) & ~1);
                    cfg.min_fp = CFG_W'(CFG_TOP);
                    cfg.max_fp = '0;
                    cfg.min_ht = CFG_W'(CFG_TOP);
                    cfg.max_ht = '0;
                end
                default: ;
            endcase
            program_registers(cfg, 1'b0);
            input_idle_on  = (phase != 1) && (phase != 3);
            output_idle_on = (phase != 1);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    n = 1;
                else if (r < 85)
                    n = $urandom_range(2, 12);
                else
                    n = $urandom_range(14, 40);
                if ($urandom_range(0, 4) == 0)
                    send_noise_cluster(n);
                else
                    send_shaped_cluster(n);
                sent += n;
            end
        end
        wait_until_idle();
    endtask

    initial
    begin
        feature_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_request > 0)
            begin
                hold_left = long_hold_request;
                long_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                feature_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                feature_ch.ready <= 1'b0;
            end
            else if (output_idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                feature_ch.ready <= 1'b0;
            end
            else
                feature_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        feature_t want;
        if (rst_n && feature_ch.valid && feature_ch.ready)
        begin
            if (pending_features.size() == 0)
            begin
                $display("%0t: unexpected feature, got index %0d value %0d", $time,
                         feature_ch.feature_index, feature_ch.feature_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_features.pop_front();
                if (feature_ch.feature_index !== want.index
                    || feature_ch.feature_value !== want.value
                    || feature_ch.last_feature !== want.last
                    || feature_ch.size_ok !== want.ok
                    || feature_ch.overflow !== want.ovf)
                begin
                    $display("%0t: mismatch, expected index %0d value %0d last %0b ok %0b ovf %0b",
                             $time, want.index, want.value, want.last, want.ok, want.ovf);
                    $display("%0t:           got index %0d value %0d last %0b ok %0b ovf %0b",
                             $time, feature_ch.feature_index, feature_ch.feature_value,
                             feature_ch.last_feature, feature_ch.size_ok, feature_ch.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        point_ch.valid      <= 1'b0;
        point_ch.point_x    <= '0;
        point_ch.point_y    <= '0;
        point_ch.point_z    <= '0;
        point_ch.last_point <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= REG_SIZE_ENABLE;
        cfg_data            <= '0;
        clear_cluster();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_points();
        test_size_limits();
        test_output_hold();
        test_random_phases();

        wait_until_idle();
        if (mismatch_count == 0)
            $display("tb_point_cluster_statistics_unit: clean");
        else
            $display("tb_point_cluster_statistics_unit: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pcs_pkg.sv
rtl/pcs_if.sv
rtl/pcs_front.sv
rtl/pcs_accum.sv
rtl/pcs_emit.sv
rtl/point_cluster_statistics_unit.sv
tb/tb_point_cluster_statistics_unit.sv
